FILE: src/ring_deque_with_indexed_insert_macros.svh
// Assertion macros for the ring deque block.
// Included by the top level; no other dependencies.
`ifndef RING_DEQUE_WITH_INDEXED_INSERT_MACROS_SVH
`define RING_DEQUE_WITH_INDEXED_INSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ring deque check failed");

// Next-cycle implication, checked outside reset.
`define RDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ring deque check failed");

`endif

FILE: src/rdq_pkg.sv
// Shared types and constants of the ring deque block.
// No dependencies; used by the channel interfaces, the cell and the top level.
`default_nettype none

package rdq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int DATA_BITS_DEF = 64;

    localparam int CMD_BITS    = 4;
    localparam int WORD_BITS   = 64;
    localparam int POS_BITS    = 5;
    localparam int COUNT_BITS  = 5;
    localparam int STATUS_BITS = 2;

    typedef logic [CMD_BITS-1:0]    t_cmd;
    typedef logic [STATUS_BITS-1:0] t_status;

    localparam t_cmd CMD_PUSH_FRONT     = 4'd0;
    localparam t_cmd CMD_PUSH_BACK      = 4'd1;
    localparam t_cmd CMD_INSERT         = 4'd2;
    localparam t_cmd CMD_POP_FRONT      = 4'd3;
    localparam t_cmd CMD_POP_BACK       = 4'd4;
    localparam t_cmd CMD_POP_FRONT_MANY = 4'd5;
    localparam t_cmd CMD_POP_BACK_MANY  = 4'd6;
    localparam t_cmd CMD_ERASE          = 4'd7;
    localparam t_cmd CMD_READ           = 4'd8;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_RANGE = 2'd1;
    localparam t_status STAT_EMPTY = 2'd2;
    localparam t_status STAT_FULL  = 2'd3;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } t_cell_op;

endpackage

`default_nettype wire

FILE: src/rdq_channels.sv
// Valid/ready channel interfaces for the ring deque commands and results.
// Depends on rdq_pkg for field widths and types.
`default_nettype none

interface rdq_cmd_if;
    import rdq_pkg::*;
    logic                 valid;
    logic                 ready;
    t_cmd                 command;
    logic [WORD_BITS-1:0] value;
    logic [POS_BITS-1:0]  position;
    logic [POS_BITS-1:0]  amount;

    modport source (output valid, command, value, position, amount, input ready);
    modport sink   (input valid, command, value, position, amount, output ready);
endinterface

interface rdq_res_if;
    import rdq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [WORD_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0] count;
    t_status               status;

    modport source (output valid, read_value, count, status, input ready);
    modport sink   (input valid, read_value, count, status, output ready);
endinterface

`default_nettype wire

FILE: src/rdq_cell.sv
// One storage cell of the deque chain: holds one entry, loads a new word
// or takes the word of either neighbor. Depends on rdq_pkg.
`default_nettype none

module rdq_cell #(
    parameter int DATA_BITS = rdq_pkg::DATA_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire rdq_pkg::t_cell_op i_op,
    input  wire  [DATA_BITS-1:0]   i_load,
    input  wire  [DATA_BITS-1:0]   i_lower,
    input  wire  [DATA_BITS-1:0]   i_upper,
    output logic [DATA_BITS-1:0]   o_data
);
    import rdq_pkg::*;

    logic [DATA_BITS-1:0] r_data;
    logic [DATA_BITS-1:0] n_data;

    always_comb begin
        case (i_op)
            CELL_LOAD:       n_data = i_load;
            CELL_FROM_LOWER: n_data = i_lower;
            CELL_FROM_UPPER: n_data = i_upper;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: src/ring_deque_with_indexed_insert.sv
// Ring deque with indexed insert and erase, built as a row of storage cells.
// Depends on rdq_pkg, rdq_channels, rdq_cell and the assertion macro header.
//
// Usage:
//   i_cmd (sink) takes one command per transfer: command, value, position,
//   amount. o_res (source) returns exactly one result per command: read_value,
//   count and status. Entries are kept in logical order, cell 0 is the front.
//   Push, insert, erase, read, pop back and pop back many finish in the cycle
//   of the transfer: the result is registered and shows in the next cycle.
//   Pop front many by n (0 < n < count) shifts the row down once per cycle
//   until n entries are gone (at most DEPTH - 1); any other pop finishes at once.
//   The result is registered at the transfer; later commands wait for the shifts.
//   Every other command sustains one command per cycle while results are
//   taken; the single output register is the only buffering, so a new
//   command is taken in the same cycle that the waiting result transfers.
//   When the receiver stalls, the result holds and i_cmd.ready stays low.
//   Reset (synchronous, active low) empties the deque and drops any pending
//   result; cell contents are not cleared and are never read before written.
//   The front pointer of a circular store is not needed here, since the cells
//   always hold the entries in front-to-back order.
`default_nettype none

module ring_deque_with_indexed_insert #(
    parameter int DEPTH     = rdq_pkg::DEPTH_DEF,
    parameter int DATA_BITS = rdq_pkg::DATA_BITS_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    rdq_cmd_if.sink   i_cmd,
    rdq_res_if.source o_res
);
    import rdq_pkg::*;

`include "ring_deque_with_indexed_insert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);            // fill count width
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // cell index width
    localparam int W  = (CW > POS_BITS) ? CW : POS_BITS;  // compare width

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SHIFT = 1'b1;

    // Control state
    logic                  r_state, n_state;
    logic [CW-1:0]         r_fill, n_fill;
    logic [POS_BITS-1:0]   r_shift_left, n_shift_left;
    logic                  r_out_valid;

    // Result payload
    logic [WORD_BITS-1:0]  r_read_value;
    logic [COUNT_BITS-1:0] r_count;
    t_status               r_status;

    // Decode
    logic                  w_take;
    logic [W-1:0]          w_fill, w_pos, w_num, w_ins_pos, w_del_pos;
    logic                  w_ins_en, w_del_en;
    t_status               w_status;
    logic [WORD_BITS-1:0]  w_read;
    logic [DATA_BITS-1:0]  w_value;
    logic                  w_full_res;

    logic [DATA_BITS-1:0]  w_cell_q [DEPTH];
    t_cell_op              w_cell_op [DEPTH];

    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_out_valid || o_res.ready);
    assign w_take      = i_cmd.valid && i_cmd.ready;

    assign w_fill  = W'(r_fill);
    assign w_pos   = W'(i_cmd.position);
    assign w_value = i_cmd.value[DATA_BITS-1:0];

    // Decide status, new count and the row action for the offered command.
    always_comb begin
        w_status     = STAT_OK;
        n_fill       = r_fill;
        w_ins_en     = 1'b0;
        w_ins_pos    = '0;
        w_del_en     = 1'b0;
        w_del_pos    = '0;
        w_read       = '0;
        n_shift_left = '0;
        w_num        = W'(i_cmd.amount);
        case (i_cmd.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                if (i_cmd.command == CMD_PUSH_FRONT) begin
                    w_ins_pos = '0;
                end else if (i_cmd.command == CMD_PUSH_BACK) begin
                    w_ins_pos = w_fill;
                end else begin
                    w_ins_pos = w_pos;
                end
                if (w_ins_pos > w_fill) begin
                    w_status = STAT_RANGE;
                end else if (r_fill == CW'(DEPTH)) begin
                    w_status = STAT_FULL;
                end else begin
                    w_ins_en = 1'b1;
                    n_fill   = r_fill + CW'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_FRONT_MANY: begin
                if (i_cmd.command == CMD_POP_FRONT) begin
                    w_num = W'(1);
                end
                if (w_num > w_fill) begin
                    w_status = STAT_EMPTY;
                end else begin
                    n_fill = CW'(w_fill - w_num);
                    // Shift down once now, the rest from the shift state;
                    // skip the shifting when nothing is popped or nothing remains.
                    if (w_num != '0 && w_num != w_fill) begin
                        w_del_en     = 1'b1;
                        w_del_pos    = '0;
                        n_shift_left = POS_BITS'(w_num - W'(1));
                    end
                end
            end
            CMD_POP_BACK, CMD_POP_BACK_MANY: begin
                if (i_cmd.command == CMD_POP_BACK) begin
                    w_num = W'(1);
                end
                if (w_num > w_fill) begin
                    w_status = STAT_EMPTY;
                end else begin
                    n_fill = CW'(w_fill - w_num);
                end
            end
            CMD_ERASE: begin
                if (w_pos >= w_fill) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_del_en  = 1'b1;
                    w_del_pos = w_pos;
                    n_fill    = r_fill - CW'(1);
                end
            end
            CMD_READ: begin
                if (w_pos >= w_fill) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_read = WORD_BITS'(w_cell_q[w_pos[IW-1:0]]);
                end
            end
            default: begin
                w_status = STAT_OK;
            end
        endcase
    end

    // Next control state: shift state for the remaining moves, then back to idle.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take && n_shift_left != '0) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (r_shift_left == POS_BITS'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fill       <= '0;
            r_shift_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SHIFT) begin
                r_shift_left <= r_shift_left - POS_BITS'(1);
            end else if (w_take) begin
                r_shift_left <= n_shift_left;
            end
            if (w_take) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on every command transfer.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_read_value <= w_read;
            r_count      <= COUNT_BITS'(n_fill);
            r_status     <= w_status;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.read_value = r_read_value;
    assign o_res.count      = r_count;
    assign o_res.status     = r_status;

    // Row of cells: each picks its action from its index against the insert or
    // delete position, or all move down in ST_SHIFT; words come from neighbors.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [W-1:0] IDX = W'(gi);
        logic [DATA_BITS-1:0] w_lower;
        logic [DATA_BITS-1:0] w_upper;

        always_comb begin
            w_cell_op[gi] = CELL_HOLD;
            if (r_state == ST_SHIFT) begin
                w_cell_op[gi] = CELL_FROM_UPPER;
            end else if (w_take && w_ins_en) begin
                if (IDX == w_ins_pos) begin
                    w_cell_op[gi] = CELL_LOAD;
                end else if (IDX > w_ins_pos) begin
                    w_cell_op[gi] = CELL_FROM_LOWER;
                end
            end else if (w_take && w_del_en) begin
                if (IDX >= w_del_pos) begin
                    w_cell_op[gi] = CELL_FROM_UPPER;
                end
            end
        end

        if (gi == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lower
            assign w_lower = w_cell_q[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_upper
            assign w_upper = w_cell_q[gi+1];
        end

        rdq_cell #(
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op[gi]),
            .i_load  (w_value),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_cell_q[gi])
        );
    end

    // Checks
    assign w_full_res = r_out_valid && (r_status == STAT_FULL);

    `RDQ_ASSERT_NOW(a_shift_blocks_input, i_clk, i_rst_n, r_state == ST_SHIFT, !i_cmd.ready)
    `RDQ_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(DEPTH))
    `RDQ_ASSERT_NOW(a_full_means_full, i_clk, i_rst_n, w_full_res, r_fill == CW'(DEPTH))
    `RDQ_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n, w_take, r_out_valid)

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the ring deque with indexed insert and erase.
// Depends on rdq_pkg, the rdq channel interfaces and the ring deque top level.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import rdq_pkg::*;

    localparam int RING_DEPTH     = DEPTH_DEF;
    localparam int PHASE_ITEMS    = 540;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 2 * RING_DEPTH + 8;

    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    // Command codes 9 to 15 are undefined: the block must leave its contents alone.
    localparam t_cmd CMD_UNDEFINED_TOP = 4'hF;

    typedef struct packed {
        t_cmd                 command;
        logic [WORD_BITS-1:0] value;
        logic [POS_BITS-1:0]  position;
        logic [POS_BITS-1:0]  amount;
    } t_cmd_item;

    typedef struct packed {
        logic [WORD_BITS-1:0]  read_value;
        logic [COUNT_BITS-1:0] count;
        t_status               status;
    } t_result;

    // One directed row: the command, how many times to send it, and, when the
    // answer is obvious, the result typed in by hand.
    typedef struct packed {
        logic [4:0] reps;
        t_cmd_item  item;
        logic       typed;
        t_result    answer;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    rdq_cmd_if cmd_ch ();
    rdq_res_if res_ch ();

    ring_deque_with_indexed_insert i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // ------------------------------------------------------------------
    // Deque predictor: circular store with a front pointer and a fill count.
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] ring [RING_DEPTH];
    int unsigned          ring_front = 0;
    int unsigned          ring_fill  = 0;

    t_result pending_results [$];
    int unsigned fail_count  = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          rx_hold_req = 1'b0;

    function automatic int unsigned slot_of(input int unsigned logical);
        return (ring_front + logical) % RING_DEPTH;
    endfunction

    function automatic t_status put_front(input logic [WORD_BITS-1:0] v);
        if (ring_fill >= RING_DEPTH) return STAT_FULL;
        ring_front = (ring_front + RING_DEPTH - 1) % RING_DEPTH;
        ring[ring_front] = v;
        ring_fill++;
        return STAT_OK;
    endfunction

    // Too many requested counts as empty; an emptied store rewinds the front.
    function automatic t_status drop_front(input int unsigned n);
        if (n > ring_fill) return STAT_EMPTY;
        ring_front = (ring_front + n) % RING_DEPTH;
        ring_fill  = ring_fill - n;
        if (ring_fill == 0) ring_front = 0;
        return STAT_OK;
    endfunction

    function automatic t_status drop_back(input int unsigned n);
        if (n > ring_fill) return STAT_EMPTY;
        ring_fill = ring_fill - n;
        if (ring_fill == 0) ring_front = 0;
        return STAT_OK;
    endfunction

    // Advance the predictor by one command and return the result it owes.
    function automatic t_result deque_apply(input t_cmd_item it);
        t_result     r;
        int unsigned j;
        r.read_value = '0;
        r.status     = STAT_OK;
        case (it.command)
            CMD_PUSH_FRONT: r.status = put_front(it.value);
            CMD_PUSH_BACK: begin
                if (ring_fill >= RING_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    ring[slot_of(ring_fill)] = it.value;
                    ring_fill++;
                end
            end
            CMD_INSERT: begin
                // Range is checked ahead of fullness.
                if (it.position > ring_fill) begin
                    r.status = STAT_RANGE;
                end else if (ring_fill >= RING_DEPTH) begin
                    r.status = STAT_FULL;
                end else if (it.position == 0) begin
                    r.status = put_front(it.value);
                end else begin
                    for (j = ring_fill; j > it.position; j--)
                        ring[slot_of(j)] = ring[slot_of(j - 1)];
                    ring[slot_of(it.position)] = it.value;
                    ring_fill++;
                end
            end
            CMD_POP_FRONT:      r.status = drop_front(1);
            CMD_POP_BACK:       r.status = drop_back(1);
            CMD_POP_FRONT_MANY: r.status = drop_front(it.amount);
            CMD_POP_BACK_MANY:  r.status = drop_back(it.amount);
            CMD_ERASE: begin
                if (it.position >= ring_fill) begin
                    r.status = STAT_RANGE;
                end else if (it.position == 0) begin
                    r.status = drop_front(1);
                end else begin
                    // At least two entries here, so the store cannot empty.
                    for (j = it.position; j + 1 < ring_fill; j++)
                        ring[slot_of(j)] = ring[slot_of(j + 1)];
                    ring_fill--;
                end
            end
            CMD_READ: begin
                if (it.position >= ring_fill)
                    r.status = STAT_RANGE;
                else
                    r.read_value = ring[slot_of(it.position)];
            end
            default: ;
        endcase
        r.count = COUNT_BITS'(ring_fill);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows: empty-store errors, the insert and erase shortcuts, a
    // full store, out-of-range indexes, an undefined command and a pop front
    // many that empties the full store.
    // ------------------------------------------------------------------
    t_dir_row directed_rows [27] = '{
        '{5'd1, '{CMD_READ,           '0, 5'd0,  5'd0},  1'b1, '{'0, 5'd0,  STAT_RANGE}},
        '{5'd1, '{CMD_POP_FRONT,      '0, 5'd0,  5'd0},  1'b1, '{'0, 5'd0,  STAT_EMPTY}},
        '{5'd1, '{CMD_POP_BACK,       '0, 5'd0,  5'd0},  1'b1, '{'0, 5'd0,  STAT_EMPTY}},
        '{5'd1, '{CMD_POP_FRONT_MANY, '0, 5'd0,  5'd0},  1'b1, '{'0, 5'd0,  STAT_OK}},
        '{5'd1, '{CMD_POP_BACK_MANY,  '0, 5'd0,  5'd1},  1'b1, '{'0, 5'd0,  STAT_EMPTY}},
        '{5'd1, '{CMD_ERASE,          '0, 5'd0,  5'd0},  1'b1, '{'0, 5'd0,  STAT_RANGE}},
        '{5'd1, '{CMD_INSERT,         '0, 5'd1,  5'd0},  1'b1, '{'0, 5'd0,  STAT_RANGE}},
        '{5'd1, '{CMD_INSERT,   ALL_ONES, 5'd0,  5'd0},  1'b1, '{'0, 5'd1,  STAT_OK}},
        '{5'd1, '{CMD_PUSH_BACK,      '0, 5'd0,  5'd0},  1'b1, '{'0, 5'd2,  STAT_OK}},
        '{5'd1, '{CMD_PUSH_FRONT, 64'h5555_5555_5555_5555, 5'd0, 5'd0},
            1'b1, '{'0, 5'd3, STAT_OK}},
        '{5'd1, '{CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 5'd3, 5'd0},
            1'b1, '{'0, 5'd4, STAT_OK}},
        '{5'd1, '{CMD_INSERT, 64'h0123_4567_89AB_CDEF, 5'd2, 5'd0},
            1'b1, '{'0, 5'd5, STAT_OK}},
        '{5'd1, '{CMD_READ,           '0, 5'd0,  5'd0},
            1'b1, '{64'h5555_5555_5555_5555, 5'd5, STAT_OK}},
        '{5'd1, '{CMD_READ,           '0, 5'd2,  5'd0},  1'b0, '0},
        '{5'd1, '{CMD_ERASE,          '0, 5'd1,  5'd0},  1'b0, '0},
        '{5'd1, '{CMD_ERASE,          '0, 5'd0,  5'd0},  1'b0, '0},
        '{5'd1, '{CMD_POP_BACK,       '0, 5'd0,  5'd0},  1'b0, '0},
        '{5'd1, '{CMD_POP_FRONT,      '0, 5'd0,  5'd0},  1'b0, '0},
        '{5'd15, '{CMD_PUSH_BACK, 64'h8000_0000_0000_0001, 5'd0, 5'd0}, 1'b0, '0},
        '{5'd1, '{CMD_READ,           '0, 5'd15, 5'd0},  1'b0, '0},
        '{5'd1, '{CMD_PUSH_FRONT, ALL_ONES, 5'd0,  5'd0},  1'b1, '{'0, 5'd16, STAT_FULL}},
        '{5'd1, '{CMD_INSERT,         '0, 5'd16, 5'd0},  1'b1, '{'0, 5'd16, STAT_FULL}},
        '{5'd1, '{CMD_INSERT,         '0, 5'd17, 5'd0},  1'b1, '{'0, 5'd16, STAT_RANGE}},
        '{5'd1, '{CMD_READ,           '0, 5'd31, 5'd0},  1'b1, '{'0, 5'd16, STAT_RANGE}},
        '{5'd1, '{CMD_UNDEFINED_TOP, ALL_ONES, 5'd31, 5'd31},
            1'b1, '{'0, 5'd16, STAT_OK}},
        '{5'd1, '{CMD_POP_BACK_MANY,  '0, 5'd0,  5'd31}, 1'b1, '{'0, 5'd16, STAT_EMPTY}},
        '{5'd1, '{CMD_POP_FRONT_MANY, '0, 5'd0,  5'd16}, 1'b1, '{'0, 5'd0,  STAT_OK}}
    };

    // ------------------------------------------------------------------
    // Clock, 2 ns period.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Command sender. Entered and left at a falling edge; drives at falling
    // edges only and samples ready at rising edges.
    // ------------------------------------------------------------------
    task automatic offer_command(input t_cmd_item it, input bit typed,
                                 input t_result typed_res);
        t_result predicted;
        // Idle the channel for a random stretch before this command.
        if ($urandom_range(99) < tx_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= it.command;
        cmd_ch.value    <= it.value;
        cmd_ch.position <= it.position;
        cmd_ch.amount   <= it.amount;
        // Hold the command until the transfer happens.
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predicted = deque_apply(it);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        int unsigned roll;
        bit          grow;
        t_cmd_item   item;

        // Known values on every input from time zero, reset held low.
        i_rst_n         = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_READ;
        cmd_ch.value    = '0;
        cmd_ch.position = '0;
        cmd_ch.amount   = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 15;
        rx_idle_pct = 47;
        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                offer_command(directed_rows[r].item, directed_rows[r].typed,
                              directed_rows[r].answer);

        // Random part: sweep the fill level up to full and back down to
        // empty so both ends and the wrap of the front pointer get exercised.
        grow = 1'b1;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 15; rx_idle_pct = 47; end
                1: begin tx_idle_pct = 47; rx_idle_pct = 15; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Stall the result side for a long stretch so the block backs up.
                if (phase < 2 && n == PHASE_ITEMS / 3) rx_hold_req = 1'b1;

                if (grow && ring_fill == RING_DEPTH && $urandom_range(1) == 1)
                    grow = 1'b0;
                else if (!grow && ring_fill == 0 && $urandom_range(1) == 1)
                    grow = 1'b1;
                else if ($urandom_range(99) < 2)
                    grow = !grow;

                item.value    = {$urandom, $urandom};
                item.position = POS_BITS'($urandom_range(ring_fill));
                if ($urandom_range(9) < 7)
                    item.amount = POS_BITS'($urandom_range(ring_fill < 3 ? ring_fill : 3));
                else
                    item.amount = POS_BITS'($urandom_range(ring_fill + 1));

                roll = $urandom_range(99);
                if (roll < 5) begin
                    // Noise: any code, any index, any amount.
                    item.command  = t_cmd'($urandom_range(15));
                    item.position = POS_BITS'($urandom_range(31));
                    item.amount   = POS_BITS'($urandom_range(31));
                end else if (roll < 25) begin
                    item.command = CMD_READ;
                end else if (roll < (grow ? 75 : 45)) begin
                    case ($urandom_range(2))
                        0:       item.command = CMD_PUSH_FRONT;
                        1:       item.command = CMD_PUSH_BACK;
                        default: item.command = CMD_INSERT;
                    endcase
                end else begin
                    case ($urandom_range(4))
                        0:       item.command = CMD_POP_FRONT;
                        1:       item.command = CMD_POP_BACK;
                        2:       item.command = CMD_POP_FRONT_MANY;
                        3:       item.command = CMD_POP_BACK_MANY;
                        default: item.command = CMD_ERASE;
                    endcase
                end
                offer_command(item, 1'b0, '0);
            end
            // Pause the sender until every result of this phase is back.
            cmd_ch.valid <= 1'b0;
            wait (pending_results.size() == 0);
            @(negedge i_clk);
        end

        // A pop front many may still be shifting; give it time to settle.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure, plus one long hold on request.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare every result transfer against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result oldest;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: read_value %h count %0d status %0d",
                       res_ch.read_value, res_ch.count, res_ch.status);
                fail_count++;
            end else begin
                oldest = pending_results[0];
                pending_results.delete(0);
                if (res_ch.read_value !== oldest.read_value) begin
                    $error("read_value mismatch: expected %h, got %h",
                           oldest.read_value, res_ch.read_value);
                    fail_count++;
                end
                if (res_ch.count !== oldest.count) begin
                    $error("count mismatch: expected %0d, got %0d",
                           oldest.count, res_ch.count);
                    fail_count++;
                end
                if (res_ch.status !== oldest.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           oldest.status, res_ch.status);
                    fail_count++;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/rdq_pkg.sv
src/rdq_channels.sv
src/rdq_cell.sv
src/ring_deque_with_indexed_insert.sv
tb/sv/tb_top.sv
